### hw/rtl/flist_pkg.sv
// Package for the fixed-capacity list engine.
// Holds sizes, operation and status codes, and the controller/datapath interface types.
// No dependencies.
package flist_pkg;

   // List capacity and the widths that follow from it.
   localparam int LIST_DEPTH = 64;
   localparam int IDX_W      = $clog2(LIST_DEPTH);
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

   // Fixed transaction field widths.
   localparam int MODE_W   = 3;
   localparam int DATA_W   = 32;
   localparam int POS_W    = 6;
   localparam int STAT_W   = 2;
   localparam int LENGTH_W = 7;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Operation codes.
   localparam logic [MODE_W-1:0] MODE_INS_FIRST = 3'd0;
   localparam logic [MODE_W-1:0] MODE_INS_POS   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_INS_LAST  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SEARCH    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_EXTREMES  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd5;

   // Status codes.
   localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd2;
   localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SHIFT,
      S_SCAN,
      S_FINISH
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              load;
      logic              shift_step;
      logic              place;
      logic              scan_step;
      logic              clear;
      logic              emit;
      logic [STAT_W-1:0] status;
   } fl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              full;
      logic              badpos;
      logic              empty;
      logic              shift_done;
      logic              scan_done;
      logic              hit;
   } fl_stat_type;

endpackage

### hw/rtl/fixed_capacity_list_engine.sv
// Sequence: accept in idle, decode, then the walk, then the load of the result register.
// Insert at p moves the entries from p upward one slot, then writes the new one; clear, spare
// modes and refusals have no walk. Search and extremes: one entry per cycle through the memory read port.
// One transaction at a time: a new request is taken only in idle, once the last result is loaded.
// Synchronous active-high reset empties the list; entry contents are left as they were.
// Depends on flist_pkg, flist_ctrl and flist_dp.
module fixed_capacity_list_engine
   import flist_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic        [MODE_W-1:0]  req_mode,
   input  logic signed [DATA_W-1:0]  req_value,
   input  logic        [POS_W-1:0]   req_position,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic        [STAT_W-1:0]  rsp_status,
   output logic        [POS_W-1:0]   rsp_found_position,
   output logic                      rsp_found,
   output logic signed [DATA_W-1:0]  rsp_max_value,
   output logic signed [DATA_W-1:0]  rsp_min_value,
   output logic      [LENGTH_W-1:0]  rsp_length
);

   fl_cmd_type  cmd;
   fl_stat_type stat;

   // Sequencing and handshakes.
   flist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Storage and arithmetic.
   flist_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_mode           (req_mode),
      .req_value          (req_value),
      .req_position       (req_position),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_found          (rsp_found),
      .rsp_max_value      (rsp_max_value),
      .rsp_min_value      (rsp_min_value),
      .rsp_length         (rsp_length)
   );

endmodule

### hw/rtl/flist_ctrl.sv
// Controller state machine of the fixed-capacity list engine.
// Sequences insert, scan and clear operations and owns the handshakes.
// Depends on flist_pkg.
module flist_ctrl
   import flist_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fl_cmd_type        cmd,
   input  fl_stat_type       stat
);

   ctrl_state_type    state_ff, state_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;
   logic              is_insert;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_insert = (stat.mode == MODE_INS_FIRST) || (stat.mode == MODE_INS_POS) ||
                      (stat.mode == MODE_INS_LAST);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (is_insert) begin
               if (stat.full || ((stat.mode == MODE_INS_POS) && stat.badpos)) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_SHIFT;
               end
            end else if ((stat.mode == MODE_SEARCH) || (stat.mode == MODE_EXTREMES)) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SHIFT: begin
            if (stat.shift_done) state_in = S_FINISH;
         end
         S_SCAN: begin
            if (stat.scan_done) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Commands and status code.
   always_comb begin
      cmd        = '0;
      cmd.status = status_ff;
      status_in  = status_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.load = req_valid;
         end
         S_DECODE: begin
            status_in = STAT_OK;
            if (is_insert) begin
               if (stat.full) begin
                  status_in = STAT_FULL;
               end else if ((stat.mode == MODE_INS_POS) && stat.badpos) begin
                  status_in = STAT_BADPOS;
               end
            end else if (stat.mode == MODE_SEARCH) begin
               status_in = STAT_EMPTY;
            end else if (stat.mode == MODE_EXTREMES) begin
               if (stat.empty) status_in = STAT_EMPTY;
            end else if (stat.mode == MODE_CLEAR) begin
               cmd.clear = 1'b1;
            end
         end
         S_SHIFT: begin
            if (stat.shift_done) begin
               cmd.place = 1'b1;
            end else begin
               cmd.shift_step = 1'b1;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.hit) status_in = STAT_OK;
         end
         S_FINISH: begin
            cmd.emit = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // The result register holds until the transaction is taken.
   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= STAT_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### hw/rtl/flist_dp.sv
// Datapath of the fixed-capacity list engine.
// Holds the entry memory, the length count, the walk pointer and the result register.
// Depends on flist_pkg.
module flist_dp
   import flist_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic        [MODE_W-1:0] req_mode,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic        [POS_W-1:0]  req_position,
   input  fl_cmd_type               cmd,
   output fl_stat_type              stat,
   output logic        [STAT_W-1:0] rsp_status,
   output logic        [POS_W-1:0]  rsp_found_position,
   output logic                     rsp_found,
   output logic signed [DATA_W-1:0] rsp_max_value,
   output logic signed [DATA_W-1:0] rsp_min_value,
   output logic      [LENGTH_W-1:0] rsp_length
);

   logic [DATA_W-1:0] mem [LIST_DEPTH];

   // Captured request.
   logic        [MODE_W-1:0] mode_ff, mode_in;
   logic        [DATA_W-1:0] value_ff, value_in;
   logic        [POS_W-1:0]  pos_ff, pos_in;

   // Walk state.
   logic        [CNT_W-1:0]  count_ff, count_in;
   logic        [CNT_W-1:0]  ptr_ff, ptr_in;
   logic        [CNT_W-1:0]  ptr_m1;
   logic        [CNT_W-1:0]  tgt;
   logic                     mv_valid_ff, mv_valid_in;
   logic        [IDX_W-1:0]  mv_addr_ff, mv_addr_in;
   logic                     rd_valid_ff, rd_valid_in;
   logic        [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic        [DATA_W-1:0] rd_data_ff;

   // Search and extremes results.
   logic                     found_ff, found_in;
   logic        [POS_W-1:0]  fpos_ff, fpos_in;
   logic signed [DATA_W-1:0] max_ff, max_in;
   logic signed [DATA_W-1:0] min_ff, min_in;
   logic                     first_ff, first_in;

   // Result register.
   logic        [STAT_W-1:0]   rsp_status_ff, rsp_status_in;
   logic        [POS_W-1:0]    rsp_fpos_ff, rsp_fpos_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic signed [DATA_W-1:0]   rsp_max_ff, rsp_max_in;
   logic signed [DATA_W-1:0]   rsp_min_ff, rsp_min_in;
   logic        [LENGTH_W-1:0] rsp_length_ff, rsp_length_in;

   // Memory port controls.
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic              hit;

   assign ptr_m1 = ptr_ff - CNT_W'(1);

   // Insert target position for the captured operation.
   always_comb begin
      case (mode_ff)
         MODE_INS_FIRST: tgt = '0;
         MODE_INS_POS:   tgt = CNT_W'(pos_ff);
         default:        tgt = count_ff;
      endcase
   end

   // Read data is only valid during a scan, so a match needs no command qualifier.
   assign hit = rd_valid_ff && (mode_ff == MODE_SEARCH) && (rd_data_ff == value_ff);

   // Status toward the controller.
   always_comb begin
      stat.mode       = mode_ff;
      stat.full       = (count_ff == CNT_W'(LIST_DEPTH));
      stat.badpos     = (CMP_W'(pos_ff) > CMP_W'(count_ff));
      stat.empty      = (count_ff == '0);
      stat.shift_done = (ptr_ff == tgt) && !mv_valid_ff;
      stat.scan_done  = hit || ((ptr_ff == count_ff) && !rd_valid_ff);
      stat.hit        = hit;
   end

   // Next-value logic for the walk, the memory ports and the result register.
   always_comb begin
      mode_in       = mode_ff;
      value_in      = value_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      mv_valid_in   = 1'b0;
      mv_addr_in    = mv_addr_ff;
      rd_valid_in   = 1'b0;
      rd_idx_in     = rd_idx_ff;
      found_in      = found_ff;
      fpos_in       = fpos_ff;
      max_in        = max_ff;
      min_in        = min_ff;
      first_in      = first_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fpos_in   = rsp_fpos_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_length_in = rsp_length_ff;
      rd_en         = 1'b0;
      rd_addr       = ptr_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = mv_addr_ff;
      wr_data       = rd_data_ff;

      // Capture a new transaction and prime the walk pointer.
      if (cmd.load) begin
         mode_in  = req_mode;
         value_in = req_value;
         pos_in   = req_position;
         if ((req_mode == MODE_SEARCH) || (req_mode == MODE_EXTREMES)) begin
            ptr_in = '0;
         end else begin
            ptr_in = count_ff;
         end
         found_in = 1'b0;
         fpos_in  = '0;
         max_in   = '0;
         min_in   = '0;
         first_in = 1'b1;
      end

      // Shift entries up one slot per cycle, from the top down to the target.
      if (cmd.shift_step) begin
         if (mv_valid_ff) wr_en = 1'b1;
         if (ptr_ff > tgt) begin
            rd_en       = 1'b1;
            rd_addr     = ptr_m1[IDX_W-1:0];
            mv_valid_in = 1'b1;
            mv_addr_in  = ptr_ff[IDX_W-1:0];
            ptr_in      = ptr_m1;
         end
      end

      // Write the new element into the opened slot.
      if (cmd.place) begin
         wr_en    = 1'b1;
         wr_addr  = tgt[IDX_W-1:0];
         wr_data  = value_ff;
         count_in = count_ff + CNT_W'(1);
      end

      // Scan entries from position 0, one read per cycle.
      if (cmd.scan_step) begin
         if ((ptr_ff < count_ff) && !hit) begin
            rd_en       = 1'b1;
            rd_valid_in = 1'b1;
            rd_idx_in   = ptr_ff[IDX_W-1:0];
            ptr_in      = ptr_ff + CNT_W'(1);
         end
         if (hit) begin
            found_in = 1'b1;
            fpos_in  = POS_W'(rd_idx_ff);
         end
         if (rd_valid_ff && (mode_ff == MODE_EXTREMES)) begin
            first_in = 1'b0;
            if (first_ff || ($signed(rd_data_ff) > max_ff)) max_in = $signed(rd_data_ff);
            if (first_ff || ($signed(rd_data_ff) < min_ff)) min_in = $signed(rd_data_ff);
         end
      end

      if (cmd.clear) count_in = '0;

      // Load the result register.
      if (cmd.emit) begin
         rsp_status_in = cmd.status;
         rsp_fpos_in   = fpos_ff;
         rsp_found_in  = found_ff;
         rsp_max_in    = max_ff;
         rsp_min_in    = min_ff;
         rsp_length_in = LENGTH_W'(count_ff);
      end
   end

   // Entry memory with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         mv_valid_ff <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         mv_valid_ff <= mv_valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      value_ff      <= value_in;
      pos_ff        <= pos_in;
      ptr_ff        <= ptr_in;
      mv_addr_ff    <= mv_addr_in;
      rd_idx_ff     <= rd_idx_in;
      found_ff      <= found_in;
      fpos_ff       <= fpos_in;
      max_ff        <= max_in;
      min_ff        <= min_in;
      first_ff      <= first_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fpos_ff   <= rsp_fpos_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_fpos_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_max_value      = rsp_max_ff;
   assign rsp_min_value      = rsp_min_ff;
   assign rsp_length         = rsp_length_ff;

endmodule

### hw/rtl/flist_chk.sv
// Port-level checker for the fixed-capacity list engine, bound to the top level.
// Depends on flist_pkg and fixed_capacity_list_engine.
module flist_chk
   import flist_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic        [MODE_W-1:0]  req_mode,
   input  logic signed [DATA_W-1:0]  req_value,
   input  logic        [POS_W-1:0]   req_position,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic        [STAT_W-1:0]  rsp_status,
   input  logic        [POS_W-1:0]   rsp_found_position,
   input  logic                      rsp_found,
   input  logic signed [DATA_W-1:0]  rsp_max_value,
   input  logic signed [DATA_W-1:0]  rsp_min_value,
   input  logic      [LENGTH_W-1:0]  rsp_length
);

   // No result transaction is offered right after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_length))
      else $error("stalled result changed");

   // The length never exceeds the capacity.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_length <= LENGTH_W'(LIST_DEPTH))
      else $error("length beyond capacity");

   // A hit is reported with status ok and at a position inside the list.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |->
         (rsp_status == STAT_OK) && (LENGTH_W'(rsp_found_position) < rsp_length))
      else $error("inconsistent search hit");

   // The reported maximum is never below the reported minimum.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_max_value >= rsp_min_value)
      else $error("maximum below minimum");

endmodule

bind fixed_capacity_list_engine flist_chk u_flist_chk (.*);

### test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the fixed-capacity list engine.
// Depends on flist_pkg and the fixed_capacity_list_engine RTL; no other files are needed.

module testbench
   import flist_pkg::*;
;

   // Spare selector values; the block answers them with status ok and leaves the list unchanged.
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
   localparam int PHASE_COUNT = 5;
   localparam int PHASE_ITEMS = 360;

   // One result transaction, as seen on the rsp_ ports.
   typedef struct {
      logic [STAT_W-1:0]        status;
      logic [POS_W-1:0]         found_position;
      logic                     found;
      logic signed [DATA_W-1:0] max_value;
      logic signed [DATA_W-1:0] min_value;
      logic [LENGTH_W-1:0]      length;
   } list_result_type;

   // Shadow copy of the list plus the queue of results still owed by the block.
   class list_tracker_type;
      logic signed [DATA_W-1:0] entries [LIST_DEPTH];
      int unsigned  count;
      list_result_type owed[$];
      int unsigned  errors, requests, checked;
      int unsigned  peak, full_refusals, bad_positions, hits, misses;

      function new();
         count = 0;
      endfunction

      // Apply one accepted request to the shadow list and queue its result.
      function void note_request(logic [MODE_W-1:0] mode, logic signed [DATA_W-1:0] value,
                                 logic [POS_W-1:0] position);
         list_result_type r;
         int unsigned  slot;
         int unsigned  idx;
         r.status         = STAT_OK;
         r.found_position = '0;
         r.found          = 1'b0;
         r.max_value      = '0;
         r.min_value      = '0;
         requests++;
         case (mode)
            MODE_INS_FIRST, MODE_INS_POS, MODE_INS_LAST: begin
               if (count >= LIST_DEPTH) begin
                  r.status = STAT_FULL;
                  full_refusals++;
               end else if (mode == MODE_INS_POS && position > count) begin
                  r.status = STAT_BADPOS;
                  bad_positions++;
               end else begin
                  if (mode == MODE_INS_FIRST)
                     slot = 0;
                  else if (mode == MODE_INS_POS)
                     slot = position;
                  else
                     slot = count;
                  for (idx = count; idx > slot; idx--)
                     entries[idx] = entries[idx - 1];
                  entries[slot] = value;
                  count++;
                  if (count > peak)
                     peak = count;
               end
            end
            MODE_SEARCH: begin
               r.status = STAT_EMPTY;
               for (idx = 0; idx < count; idx++) begin
                  if (entries[idx] == value) begin
                     r.status         = STAT_OK;
                     r.found          = 1'b1;
                     r.found_position = POS_W'(idx);
                     break;
                  end
               end
               if (r.found)
                  hits++;
               else
                  misses++;
            end
            MODE_EXTREMES: begin
               if (count == 0) begin
                  r.status = STAT_EMPTY;
               end else begin
                  r.max_value = entries[0];
                  r.min_value = entries[0];
                  for (idx = 1; idx < count; idx++) begin
                     if (entries[idx] > r.max_value)
                        r.max_value = entries[idx];
                     if (entries[idx] < r.min_value)
                        r.min_value = entries[idx];
                  end
               end
            end
            MODE_CLEAR: count = 0;
            default: ;
         endcase
         r.length = LENGTH_W'(count);
         owed.push_back(r);
      endfunction

      // Compare one result transaction against the oldest owed result.
      function void check_response(list_result_type got);
         list_result_type want;
         if (owed.size() == 0) begin
            $error("result transaction arrived with no request outstanding");
            errors++;
            return;
         end
         want = owed.pop_front();
         checked++;
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.found_position !== want.found_position) begin
            $error("found_position: expected %0d, got %0d",
                   want.found_position, got.found_position);
            errors++;
         end
         if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            errors++;
         end
         if (got.max_value !== want.max_value) begin
            $error("max_value: expected %0d, got %0d", want.max_value, got.max_value);
            errors++;
         end
         if (got.min_value !== want.min_value) begin
            $error("min_value: expected %0d, got %0d", want.min_value, got.min_value);
            errors++;
         end
         if (got.length !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, got.length);
            errors++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic        [MODE_W-1:0]  req_mode;
   logic signed [DATA_W-1:0]  req_value;
   logic        [POS_W-1:0]   req_position;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic        [STAT_W-1:0]  rsp_status;
   logic        [POS_W-1:0]   rsp_found_position;
   logic                      rsp_found;
   logic signed [DATA_W-1:0]  rsp_max_value;
   logic signed [DATA_W-1:0]  rsp_min_value;
   logic      [LENGTH_W-1:0]  rsp_length;

   list_tracker_type tracker = new();
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned stall_hold    = 0;

   fixed_capacity_list_engine u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_value          (req_value),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_found          (rsp_found),
      .rsp_max_value      (rsp_max_value),
      .rsp_min_value      (rsp_min_value),
      .rsp_length         (rsp_length)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard limit on the run time.
   initial begin
      #8ms;
      $display("TB_ERROR");
      $finish;
   end

   // Offer one request transaction and hold it until the block takes it.
   task automatic send_request(input logic [MODE_W-1:0] mode,
                               input logic signed [DATA_W-1:0] value,
                               input logic [POS_W-1:0] position);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_value    <= value;
      req_position <= position;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      tracker.note_request(mode, value, position);
   endtask

   // Data values lean on the extremes and on a narrow band so duplicates are common.
   function automatic logic signed [DATA_W-1:0] pick_value();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
         endcase
      end
      if (pick < 50)
         return DATA_W'($signed($urandom_range(0, 15)) - 8);
      return $urandom;
   endfunction

   // One random request; clears are rare in some phases so the list runs full.
   task automatic send_random_request(input int unsigned clear_per_mille);
      int unsigned              pick;
      logic [MODE_W-1:0]        mode;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
      pick = $urandom_range(0, 999);
      if (pick < clear_per_mille)
         mode = MODE_CLEAR;
      else if (pick < clear_per_mille + 8)
         mode = MODE_SPARE_LO;
      else if (pick < clear_per_mille + 16)
         mode = MODE_SPARE_HI;
      else begin
         pick = $urandom_range(0, 99);
         if (pick < 18)
            mode = MODE_INS_FIRST;
         else if (pick < 40)
            mode = MODE_INS_POS;
         else if (pick < 58)
            mode = MODE_INS_LAST;
         else if (pick < 80)
            mode = MODE_SEARCH;
         else
            mode = MODE_EXTREMES;
      end
      value = pick_value();
      // Searches mostly look for something that is in the list.
      if (mode == MODE_SEARCH && tracker.count > 0 && $urandom_range(0, 99) < 65)
         value = tracker.entries[$urandom_range(0, tracker.count - 1)];
      // Positions are mostly legal; the rest cover the whole field.
      if ($urandom_range(0, 99) < 85)
         position = POS_W'($urandom_range(0, (tracker.count > 63) ? 63 : tracker.count));
      else
         position = POS_W'($urandom_range(0, 63));
      send_request(mode, value, position);
   endtask

   // Result side: check each accepted transaction, then pick the next stall.
   initial begin : result_side
      list_result_type seen;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            seen.status         = rsp_status;
            seen.found_position = rsp_found_position;
            seen.found          = rsp_found;
            seen.max_value      = rsp_max_value;
            seen.min_value      = rsp_min_value;
            seen.length         = rsp_length;
            tracker.check_response(seen);
         end
         if (stall_hold > 0) begin
            stall_hold = stall_hold - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
         end
      end
   end

   // Stimulus: reset, directed corner cases, then random phases.
   initial begin : stimulus
      int unsigned phase_idle  [PHASE_COUNT] = '{0, 52, 0, 34, 0};
      int unsigned phase_stall [PHASE_COUNT] = '{0, 0, 52, 34, 0};
      int unsigned phase_clear [PHASE_COUNT] = '{3, 40, 5, 60, 3};
      req_valid    <= 1'b0;
      req_mode     <= MODE_INS_FIRST;
      req_value    <= '0;
      req_position <= '0;
      reset        <= 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty list queries, position checks on an empty list, then a small list.
      send_request(MODE_EXTREMES, 32'sd0, 6'd0);
      send_request(MODE_SEARCH, 32'sd5, 6'd0);
      send_request(MODE_INS_POS, 32'sd7, 6'd1);
      send_request(MODE_INS_POS, 32'sd7, 6'd0);
      send_request(MODE_INS_FIRST, 32'h7FFF_FFFF, 6'd0);
      send_request(MODE_INS_LAST, 32'h8000_0000, 6'd63);
      send_request(MODE_INS_POS, 32'hFFFF_FFFF, 6'd1);
      send_request(MODE_INS_POS, 32'sd7, 6'd4);
      send_request(MODE_INS_POS, 32'sd0, 6'd63);
      send_request(MODE_SEARCH, 32'sd7, 6'd0);
      send_request(MODE_SEARCH, 32'h8000_0000, 6'd0);
      send_request(MODE_SEARCH, 32'sd12345, 6'd0);
      send_request(MODE_EXTREMES, 32'sd0, 6'd0);
      send_request(MODE_SPARE_LO, 32'hFFFF_FFFF, 6'd63);
      send_request(MODE_SPARE_HI, 32'h5555_AAAA, 6'd42);
      send_request(MODE_CLEAR, 32'sd0, 6'd0);
      send_request(MODE_EXTREMES, 32'sd0, 6'd0);
      send_request(MODE_CLEAR, 32'sd0, 6'd0);
      send_request(MODE_INS_LAST, -32'sd5, 6'd0);
      send_request(MODE_EXTREMES, 32'sd0, 6'd0);
      send_request(MODE_SEARCH, -32'sd5, 6'd0);

      // Random phases with different idling on each side.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         send_idle_pct = phase_idle[p];
         rsp_stall_pct = phase_stall[p];
         // Hold the result side off for a long stretch so the input backs up.
         if (p == PHASE_COUNT - 1)
            stall_hold = 500;
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_random_request(phase_clear[p]);
      end
      req_valid <= 1'b0;

      // Drain, then give the block time to show any stray result.
      rsp_stall_pct = 0;
      while (tracker.owed.size() != 0)
         @(posedge clock);
      repeat (LIST_DEPTH + 16) @(posedge clock);

      $display("Run covered %0d requests and %0d checked results; peak length %0d.",
               tracker.requests, tracker.checked, tracker.peak);
      $display("Refusals: %0d full, %0d bad position; searches: %0d hits, %0d misses.",
               tracker.full_refusals, tracker.bad_positions, tracker.hits, tracker.misses);
      if (tracker.errors == 0 && tracker.owed.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
